### rtl/core/ring_buffered_frame_extractor_macros.svh
// ----------------------------------------------------------------------------
// Ring buffered frame extractor assertion macros
// Shorthand for clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFERED_FRAME_EXTRACTOR_MACROS_SVH
`define RING_BUFFERED_FRAME_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define RBFE_ASSERT_IMM(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RBFE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rbfe_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffered frame extractor package
// Shared codes, widths and reset values.
// ----------------------------------------------------------------------------
package rbfe_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_STORED  = 2'd0;
  localparam status_t ST_DROPPED = 2'd1;
  localparam status_t ST_FRAME   = 2'd2;
  localparam status_t ST_NONE    = 2'd3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_MINLEN = 1'b1;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam byte_t HEADER_RST = 8'hAA;
  localparam len_t  MINLEN_RST = 7'd4;
  localparam len_t  MINLEN_FLOOR = 7'd3;

endpackage

### rtl/core/rbfe_ram.sv
// ----------------------------------------------------------------------------
// Ring buffered frame extractor RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rbfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/ring_buffered_frame_extractor.sv
// ----------------------------------------------------------------------------
// Ring buffered frame extractor
// Byte ring with a header, length and checksum frame finder.
// ----------------------------------------------------------------------------
// An append transaction returns its single result, registered, on the next
// cycle; appends may arrive every cycle while busy is low, and the ring holds
// RING_DEPTH-1 bytes. A fetch transaction raises busy and walks the ring
// through its single read port: a start byte is checked against the header
// and the length byte and is either rejected or taken as a candidate frame of
// length L, whose L bytes are read to check the checksum; a found frame is then
// emitted one byte per cycle over consecutive cycles. Results are shown for one
// cycle on out_strobe and cannot be held off; the receiver must take every one.
// ----------------------------------------------------------------------------
module ring_buffered_frame_extractor #(
  parameter int RING_DEPTH = 128,
  parameter int MAX_FRAME  = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  rbfe_pkg::byte_t       in_data_byte,
  output logic                  out_strobe,
  output rbfe_pkg::status_t     out_status,
  output rbfe_pkg::byte_t       out_out_byte,
  output rbfe_pkg::len_t        out_frame_length,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  rbfe_pkg::byte_t       cfg_data
);

  import rbfe_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = (AW > BYTE_W) ? AW : BYTE_W;
  localparam int SW = ((AW > LEN_W) ? AW : LEN_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_HDR  = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base, input len_t off);
    logic [SW-1:0] s;
    begin
      s = SW'(base) + SW'(off);
      if (s >= SW'(RING_DEPTH)) begin
        s = s - SW'(RING_DEPTH);
      end
      return s[AW-1:0];
    end
  endfunction

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  len_t          idx_r, idx_nxt;
  len_t          len_r, len_nxt;
  byte_t         sum_r, sum_nxt;
  byte_t         hdr_r;
  len_t          minlen_r;

  logic          out_strobe_r, out_strobe_nxt;
  status_t       out_status_r, out_status_nxt;
  byte_t         out_byte_r, out_byte_nxt;
  len_t          out_len_r, out_len_nxt;
  logic          out_last_r, out_last_nxt;

  logic [AW-1:0] count;
  logic [CW-1:0] count_x;
  len_t          minlen_eff;
  logic          full;
  logic          accept;
  len_t          off;
  logic [AW-1:0] raddr;
  byte_t         ram_q;
  logic          ram_we;

  assign accept     = start && (state_r == S_IDLE);
  assign busy       = (state_r != S_IDLE);
  assign count      = (wp_r >= rp_r) ? (wp_r - rp_r) : AW'(SW'(wp_r) + SW'(RING_DEPTH) - SW'(rp_r));
  assign count_x    = CW'(count);
  assign minlen_eff = (minlen_r < MINLEN_FLOOR) ? MINLEN_FLOOR : minlen_r;
  assign full       = (count == AW'(RING_DEPTH - 1));
  assign ram_we     = accept && (in_operation == OP_APPEND) && !full;
  assign raddr      = wrap_add(rp_r, off);

  always_comb begin
    unique case (state_r)
      S_HDR:   off = len_t'(1);
      S_LEN:   off = len_t'(2);
      S_SUM:   off = idx_r + len_t'(1);
      S_EMIT:  off = idx_r;
      default: off = '0;
    endcase
  end

  rbfe_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_DEPTH)
  ) u_rbfe_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(in_data_byte),
    .raddr(raddr),
    .rdata(ram_q)
  );

  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    idx_nxt        = idx_r;
    len_nxt        = len_r;
    sum_nxt        = sum_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_APPEND) begin
            out_strobe_nxt = 1'b1;
            out_byte_nxt   = '0;
            out_len_nxt    = '0;
            out_last_nxt   = 1'b1;
            if (full) begin
              out_status_nxt = ST_DROPPED;
            end else begin
              out_status_nxt = ST_STORED;
              wp_nxt         = wrap_add(wp_r, len_t'(1));
            end
          end else begin
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (count_x < CW'(minlen_eff)) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_NONE;
          out_byte_nxt   = '0;
          out_len_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (ram_q != hdr_r) begin
          rp_nxt    = wrap_add(rp_r, len_t'(1));
          state_nxt = S_CHK;
        end else begin
          sum_nxt   = ram_q;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if ((ram_q < BYTE_W'(minlen_eff)) || (ram_q > BYTE_W'(MAX_FRAME))) begin
          rp_nxt    = wrap_add(rp_r, len_t'(1));
          state_nxt = S_CHK;
        end else if (count_x < CW'(ram_q)) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_NONE;
          out_byte_nxt   = '0;
          out_len_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          len_nxt   = ram_q[LEN_W-1:0];
          sum_nxt   = sum_r + ram_q;
          idx_nxt   = len_t'(2);
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (idx_r == len_r - len_t'(1)) begin
          if (ram_q == sum_r) begin
            idx_nxt   = '0;
            state_nxt = S_EMIT;
          end else begin
            rp_nxt    = wrap_add(rp_r, len_t'(1));
            state_nxt = S_CHK;
          end
        end else begin
          sum_nxt = sum_r + ram_q;
          idx_nxt = idx_r + len_t'(1);
        end
      end
      S_EMIT: begin
        if (idx_r != '0) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = ST_FRAME;
          out_byte_nxt   = ram_q;
          out_len_nxt    = len_r;
          out_last_nxt   = (idx_r == len_r);
        end
        if (idx_r == len_r) begin
          rp_nxt    = wrap_add(rp_r, len_r);
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + len_t'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rp_r         <= '0;
      wp_r         <= '0;
      out_strobe_r <= 1'b0;
      hdr_r        <= HEADER_RST;
      minlen_r     <= MINLEN_RST;
    end else begin
      state_r      <= state_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HEADER: hdr_r    <= cfg_data;
          CFG_MINLEN: minlen_r <= cfg_data[LEN_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    len_r        <= len_nxt;
    sum_r        <= sum_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_out_byte     = out_byte_r;
  assign out_frame_length = out_len_r;
  assign out_last         = out_last_r;

endmodule

### rtl/core/rbfe_checker.sv
// ----------------------------------------------------------------------------
// Ring buffered frame extractor checker
// Port-level checks on result sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "ring_buffered_frame_extractor_macros.svh"

module rbfe_checker #(
  parameter int MAX_FRAME = 64
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  in_operation,
  input logic                  out_strobe,
  input rbfe_pkg::status_t     out_status,
  input rbfe_pkg::byte_t       out_out_byte,
  input rbfe_pkg::len_t        out_frame_length,
  input logic                  out_last
);

  import rbfe_pkg::*;

  logic append_acc;
  logic fetch_acc;
  logic frame_mid;

  assign append_acc = start && !busy && (in_operation == OP_APPEND);
  assign fetch_acc  = start && !busy && (in_operation == OP_FETCH);
  assign frame_mid  = out_strobe && (out_status == ST_FRAME) && !out_last;

  `RBFE_ASSERT_NXT(a_append_result, clk, rst_n, append_acc, out_strobe && out_last && ((out_status == ST_STORED) || (out_status == ST_DROPPED)), "append transaction without its single result")
  `RBFE_ASSERT_NXT(a_fetch_busy, clk, rst_n, fetch_acc, busy && !out_strobe, "fetch transaction did not hold busy")
  `RBFE_ASSERT_NXT(a_frame_burst, clk, rst_n, frame_mid, out_strobe && (out_status == ST_FRAME) && $stable(out_frame_length), "frame burst broken")
  `RBFE_ASSERT_IMM(a_frame_len, clk, rst_n, out_strobe && (out_status == ST_FRAME), (out_frame_length >= MINLEN_FLOOR) && (out_frame_length <= LEN_W'(MAX_FRAME)), "frame length out of range")
  `RBFE_ASSERT_IMM(a_single_zero, clk, rst_n, out_strobe && (out_status != ST_FRAME), out_last && (out_out_byte == '0) && (out_frame_length == '0), "single result not cleared")

endmodule

bind ring_buffered_frame_extractor rbfe_checker #(.MAX_FRAME(MAX_FRAME)) u_rbfe_checker (.*);

### tb/sv/tb_ring_buffered_frame_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffered frame extractor testbench
// Sends byte appends and frame fetches through the start/busy port. A local
// mirror of the ring and of the frame search predicts every result, and each
// strobed result is compared with the oldest prediction. Directed frames come
// first, then a full ring of longest frames, then random traffic under extreme
// and random register settings, with random sending gaps outside the full ring.
// ----------------------------------------------------------------------------
module tb_ring_buffered_frame_extractor;
  import rbfe_pkg::*;

  localparam int RING_DEPTH  = 128;
  localparam int MAX_FRAME   = 64;
  localparam int STALL_LIMIT = 50000;

  typedef struct packed {
    status_t status;
    byte_t   data;
    len_t    flen;
    logic    last;
  } frame_result_t;

  typedef enum {SHAPE_GOOD, SHAPE_BAD_SUM, SHAPE_BAD_LEN} frame_shape_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  logic    in_operation = OP_APPEND;
  byte_t   in_data_byte = '0;
  logic    out_strobe;
  status_t out_status;
  byte_t   out_out_byte;
  len_t    out_frame_length;
  logic    out_last;
  logic    cfg_we = 1'b0;
  logic    cfg_index = CFG_HEADER;
  byte_t   cfg_data = '0;

  byte_t         ring_mirror [RING_DEPTH];
  int unsigned   rd_ptr;
  int unsigned   wr_ptr;
  byte_t         hdr_cfg;
  len_t          min_len_cfg;
  frame_result_t results_due [$];
  frame_result_t head_result;

  int unsigned idle_pct = 31;
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  int unsigned frames_found = 0;
  int unsigned empty_fetches = 0;
  int unsigned bytes_dropped = 0;
  int unsigned cfg_writes = 0;
  int unsigned stall_cycles = 0;
  bit          fetch_hit;

  ring_buffered_frame_extractor #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_FRAME (MAX_FRAME)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_out_byte    (out_out_byte),
    .out_frame_length(out_frame_length),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned ring_fill();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  function automatic byte_t ring_at(input int unsigned offset);
    return ring_mirror[(rd_ptr + offset) % RING_DEPTH];
  endfunction

  function automatic int unsigned eff_min_len();
    return (min_len_cfg < MINLEN_FLOOR) ? MINLEN_FLOOR : min_len_cfg;
  endfunction

  task automatic predict_extraction(input logic op, input byte_t data);
    int unsigned min_eff;
    int unsigned fill;
    int unsigned flen;
    int unsigned i;
    byte_t       sum;
    bit          searching;
    min_eff = eff_min_len();
    if (op == OP_APPEND) begin
      if (ring_fill() >= RING_DEPTH - 1) begin
        results_due.push_back('{ST_DROPPED, 8'd0, 7'd0, 1'b1});
        bytes_dropped++;
      end else begin
        ring_mirror[wr_ptr] = data;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        results_due.push_back('{ST_STORED, 8'd0, 7'd0, 1'b1});
      end
    end else begin
      searching = 1'b1;
      fetch_hit = 1'b0;
      while (searching) begin
        fill = ring_fill();
        if (fill < min_eff) begin
          searching = 1'b0;
        end else if (ring_at(0) != hdr_cfg) begin
          rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        end else begin
          flen = ring_at(1);
          if (flen < min_eff || flen > MAX_FRAME) begin
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
          end else if (fill < flen) begin
            searching = 1'b0;
          end else begin
            sum = '0;
            for (i = 0; i + 1 < flen; i++) sum = sum + ring_at(i);
            if (sum != ring_at(flen - 1)) begin
              rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end else begin
              for (i = 0; i < flen; i++)
                results_due.push_back('{ST_FRAME, ring_at(i), len_t'(flen), i + 1 == flen});
              rd_ptr = (rd_ptr + flen) % RING_DEPTH;
              fetch_hit = 1'b1;
              searching = 1'b0;
            end
          end
        end
      end
      if (fetch_hit) begin
        frames_found++;
      end else begin
        results_due.push_back('{ST_NONE, 8'd0, 7'd0, 1'b1});
        empty_fetches++;
      end
    end
  endtask

  task automatic send_item(input logic op, input byte_t data);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    in_operation <= op;
    in_data_byte <= data;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_extraction(op, data);
    items_sent++;
  endtask

  task automatic append_frame(input frame_shape_t shape, input int unsigned flen);
    byte_t       sum;
    byte_t       b;
    byte_t       len_byte;
    int unsigned i;
    len_byte = (shape == SHAPE_BAD_LEN) ? byte_t'($urandom) : byte_t'(flen);
    send_item(OP_APPEND, hdr_cfg);
    send_item(OP_APPEND, len_byte);
    sum = hdr_cfg + len_byte;
    for (i = 2; i + 1 < flen; i++) begin
      b = byte_t'($urandom);
      send_item(OP_APPEND, b);
      sum = sum + b;
    end
    if (shape == SHAPE_BAD_SUM) sum = sum ^ byte_t'($urandom_range(1, 255));
    send_item(OP_APPEND, sum);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input byte_t value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CFG_HEADER) hdr_cfg = value;
    else min_len_cfg = len_t'(value);
    cfg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input byte_t hdr, input byte_t min_len);
    wait_idle();
    write_cfg(CFG_HEADER, hdr);
    write_cfg(CFG_MINLEN, min_len);
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned first;
    int unsigned lo;
    int unsigned hi;
    int unsigned flen;
    int unsigned sel;
    int unsigned n;
    int unsigned k;
    first = items_sent;
    lo = eff_min_len();
    if (lo > MAX_FRAME) lo = MINLEN_FLOOR;
    hi = (lo + 5 > MAX_FRAME) ? MAX_FRAME : lo + 5;
    while (items_sent - first < budget) begin
      sel = $urandom_range(0, 99);
      flen = $urandom_range(lo, hi);
      if (sel < 50) begin
        append_frame(SHAPE_GOOD, flen);
        if ($urandom_range(0, 9) < 7) send_item(OP_FETCH, byte_t'($urandom));
      end else if (sel < 62) begin
        append_frame(($urandom_range(0, 1) == 0) ? SHAPE_BAD_SUM : SHAPE_BAD_LEN, flen);
      end else if (sel < 82) begin
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++)
          send_item(OP_APPEND, ($urandom_range(0, 3) == 0) ? hdr_cfg : byte_t'($urandom));
      end else begin
        send_item(OP_FETCH, byte_t'($urandom));
      end
    end
  endtask

  task automatic test_directed_frames();
    // empty ring
    send_item(OP_FETCH, 8'h00);
    // wrong headers, length below minimum and above maximum, then a good frame
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'h03);
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'h41);
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'h04);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, 8'hAD);
    send_item(OP_FETCH, 8'hFF);
    // bad checksum, leaving too few bytes behind
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'h04);
    send_item(OP_APPEND, 8'h10);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_FETCH, 8'h00);
    // frame longer than the buffered bytes, completed later
    send_item(OP_APPEND, 8'hAA);
    send_item(OP_APPEND, 8'h06);
    send_item(OP_APPEND, 8'h01);
    send_item(OP_APPEND, 8'h02);
    send_item(OP_FETCH, 8'h00);
    send_item(OP_APPEND, 8'h03);
    send_item(OP_APPEND, 8'hB6);
    send_item(OP_FETCH, 8'h00);
  endtask

  task automatic test_ring_full();
    idle_pct = 0;
    // largest minimum and longest frames
    set_config(8'hFF, 8'd64);
    while (ring_fill() < RING_DEPTH - 1) append_frame(SHAPE_GOOD, MAX_FRAME);
    send_item(OP_APPEND, byte_t'($urandom));
    send_item(OP_APPEND, byte_t'($urandom));
    do send_item(OP_FETCH, byte_t'($urandom)); while (fetch_hit);
    idle_pct = 31;
  endtask

  task automatic test_config_extremes();
    // minimum length zero acts as three
    set_config(8'h00, 8'h00);
    run_traffic(4);
    // minimum above the largest frame: nothing can match
    set_config(8'h3C, 8'hFF);
    run_traffic(3);
  endtask

  task automatic test_random_traffic();
    set_config(byte_t'($urandom), byte_t'($urandom_range(3, 9)));
    run_traffic(6);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: status %0d, out_byte %0d", out_status, out_out_byte);
        mismatches++;
      end else begin
        head_result = results_due.pop_front();
        if (out_status !== head_result.status) begin
          $error("status: expected %0d, actual %0d", head_result.status, out_status);
          mismatches++;
        end
        if (out_out_byte !== head_result.data) begin
          $error("out_byte: expected %0d, actual %0d", head_result.data, out_out_byte);
          mismatches++;
        end
        if (out_frame_length !== head_result.flen) begin
          $error("frame_length: expected %0d, actual %0d", head_result.flen,
                 out_frame_length);
          mismatches++;
        end
        if (out_last !== head_result.last) begin
          $error("last: expected %0d, actual %0d", head_result.last, out_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb_ring_buffered_frame_extractor failed");
    $finish;
  end

  initial begin
    rd_ptr = 0;
    wr_ptr = 0;
    hdr_cfg = HEADER_RST;
    min_len_cfg = MINLEN_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_frames();
    test_ring_full();
    test_config_extremes();
    test_random_traffic();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d transactions and %0d register writes", items_sent, cfg_writes);
    $display("frames extracted %0d, fetches without frame %0d, bytes dropped %0d",
             frames_found, empty_fetches, bytes_dropped);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb_ring_buffered_frame_extractor passed");
    end else begin
      $display("tb_ring_buffered_frame_extractor failed");
    end
    $finish;
  end

endmodule
